// ----- sv/dda_pkg.sv -----
// shared types and constants for the styled dda line rasteriser
// used by dda_div, dda_pattern and dda_styled_line_rasterizer_core
package dda_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STYLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_LENGTH = 1'b1;

  // line style codes
  localparam logic [1:0] STYLE_SOLID = 2'd0;
  localparam logic [1:0] STYLE_DASHED = 2'd1;
  localparam logic [1:0] STYLE_DASH_DOT = 2'd2;

  localparam logic [5:0] DASH_LENGTH_RESET = 6'd10;
  localparam logic [5:0] DASH_LENGTH_MIN = 6'd2;
  localparam logic [6:0] DOT_OFFSET = 7'd3;
  localparam logic [6:0] DASH_DOT_EXTRA = 7'd5;

  // input word kinds carried on tuser
  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } dda_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- sv/dda_div.sv -----
// iterative restoring divider: one compare and subtract per cycle
// computes (dividend << FRAC_BITS) / divisor for dividend <= divisor; uses dda_pkg
module dda_div #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [COORD_BITS-1:0]    dividend,
  input  logic [COORD_BITS-1:0]    divisor,
  output logic [FRAC_BITS:0]       quotient,
  output dda_pkg::div_status_t     status
);
  import dda_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic [COORD_BITS:0]   rem;
  logic [COORD_BITS-1:0] dvs;
  logic [FRAC_BITS:0]    quo;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;

  logic                  ge;
  logic [COORD_BITS:0]   diff;

  assign ge = rem >= {1'b0, dvs};
  assign diff = ge ? (rem - {1'b0, dvs}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // remainder stays below the divisor after each step, so the shift fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend};
      dvs <= divisor;
      cnt <= CW'(FRAC_BITS);
    end else if (busy) begin
      rem <= {diff[COORD_BITS-1:0], 1'b0};
      quo <= {quo[FRAC_BITS-1:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = quo;
  assign status = '{busy: busy, done: done};

endmodule

// ----- sv/dda_pattern.sv -----
// style pattern: next position in the dash period and its lit flag
// uses line style codes and constants from dda_pkg
module dda_pattern (
  input  logic [1:0] line_style,
  input  logic [5:0] dash_length,
  input  logic [6:0] pos,
  output logic [6:0] pos_next,
  output logic       lit
);
  import dda_pkg::*;

  logic [5:0] len;
  logic [6:0] len_w;
  logic [6:0] period;
  logic [6:0] pos_inc;

  assign len = (dash_length < DASH_LENGTH_MIN) ? DASH_LENGTH_MIN : dash_length;
  assign len_w = {1'b0, len};
  assign pos_inc = pos + 7'd1;

  always_comb begin
    unique case (line_style)
      STYLE_DASHED:   period = len_w;
      STYLE_DASH_DOT: period = len_w + DASH_DOT_EXTRA;
      default:        period = 7'd1;
    endcase
  end

  // wrap whenever the period is reached or passed, also after a mid-line change
  assign pos_next = (pos_inc >= period) ? 7'd0 : pos_inc;

  always_comb begin
    unique case (line_style)
      STYLE_DASHED:   lit = (pos_next != 7'd0) && (pos_next != 7'd1);
      STYLE_DASH_DOT: lit = ((pos_next >= 7'd1) && (pos_next <= len_w))
                            || (pos_next == len_w + DOT_OFFSET);
      default:        lit = 1'b1;
    endcase
  end

endmodule

// ----- sv/dda_styled_line_rasterizer_core.sv -----
// top level of the styled dda line rasteriser: sequencer, accumulators, output register
// instantiates dda_div and dda_pattern; uses dda_pkg
//
// A start word (tuser 0) carries both endpoints; the start point leaves at once, lit,
// and the per-step x and y increments are then formed one after the other on a single
// shared restoring divider, one quotient bit a cycle, so the block takes no new word
// after a start until both divisions are done. A zero-length line gives only the start
// point, marked last, and needs no division. Each advance word (tuser 1) gives one point,
// truncated toward zero, with tuser the lit flag of the style pattern and tlast on the
// endpoint, which is sent exactly; advances while no line is open give nothing. A new
// word is taken once the output register is empty or being drained, so advances run at
// one point a clock when the sink keeps up.
module dda_styled_line_rasterizer_core #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [dda_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [dda_pkg::CFG_DATA_W-1:0]             cfg_data,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // x_start, y_start, x_end, y_end, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]          s_tdata,
  // action
  input  logic                                       s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // point_x, point_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_tdata,
  // lit
  output logic                                       m_tuser,
  output logic                                       m_tlast
);
  import dda_pkg::*;

  localparam int C = COORD_BITS;
  localparam int AW = COORD_BITS + FRAC_BITS;
  localparam int SW = FRAC_BITS + 2;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  logic [1:0] line_style;
  logic [5:0] dash_length;

  dda_state_t state, state_next;

  logic signed [AW-1:0] x_accum, y_accum;
  logic [SW-1:0]        x_step, y_step;
  logic [C-1:0]         total_steps, step_count;
  logic [6:0]           pattern_pos;
  logic                 line_active;
  logic [C-1:0]         end_x, end_y;
  logic                 x_neg, y_neg;
  logic [C-1:0]         y_mag;
  logic [C-1:0]         point_x, point_y;
  logic                 lit, last;

  logic signed [C-1:0] x_s, y_s, x_e, y_e;
  logic signed [C:0]   dx, dy;
  logic [C:0]          dx_abs, dy_abs;
  logic [C-1:0]        dx_mag, dy_mag, steps;

  logic                accept, start_acc, adv_acc, emit;
  logic                div_start;
  logic [C-1:0]        div_operand, div_divisor;
  logic [FRAC_BITS:0]  div_q;
  div_status_t         div_stat;
  logic [SW-1:0]       q_ext, q_signed;
  logic                q_neg;

  logic signed [AW-1:0] x_sum, y_sum, x_rnd, y_rnd;
  logic [C:0]           count_inc;
  logic [6:0]           pos_next;
  logic                 pat_lit;

  assign x_s = s_tdata[C-1:0];
  assign y_s = s_tdata[2*C-1:C];
  assign x_e = s_tdata[3*C-1:2*C];
  assign y_e = s_tdata[4*C-1:3*C];

  assign dx = {x_e[C-1], x_e} - {x_s[C-1], x_s};
  assign dy = {y_e[C-1], y_e} - {y_s[C-1], y_s};
  assign dx_abs = dx[C] ? (~dx + 1'b1) : dx;
  assign dy_abs = dy[C] ? (~dy + 1'b1) : dy;
  assign dx_mag = dx_abs[C-1:0];
  assign dy_mag = dy_abs[C-1:0];
  assign steps = (dx_mag > dy_mag) ? dx_mag : dy_mag;

  assign accept = s_tvalid && s_tready;
  assign start_acc = accept && (s_tuser == ACTION_START);
  assign adv_acc = accept && (s_tuser == ACTION_ADVANCE);
  assign emit = start_acc || (adv_acc && line_active);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_style <= STYLE_SOLID;
      dash_length <= DASH_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_STYLE:  line_style <= cfg_data[1:0];
        CFG_DASH_LENGTH: dash_length <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_operand = dx_mag;
    div_divisor = total_steps;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        div_divisor = steps;
        if (start_acc && steps != '0) begin
          div_start = 1'b1;
          state_next = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_operand = y_mag;
          state_next = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_operand),
    .divisor(div_divisor),
    .quotient(div_q),
    .status(div_stat)
  );

  dda_pattern u_pattern (
    .line_style(line_style),
    .dash_length(dash_length),
    .pos(pattern_pos),
    .pos_next(pos_next),
    .lit(pat_lit)
  );

  assign q_ext = {1'b0, div_q};
  assign q_neg = (state == ST_DIV_X) ? x_neg : y_neg;
  assign q_signed = q_neg ? (~q_ext + 1'b1) : q_ext;

  assign x_sum = x_accum + {{(AW-SW){x_step[SW-1]}}, x_step};
  assign y_sum = y_accum + {{(AW-SW){y_step[SW-1]}}, y_step};
  // bias negative values so the arithmetic shift truncates toward zero
  assign x_rnd = x_sum + (x_sum[AW-1] ? AW'({FRAC_BITS{1'b1}}) : AW'(0));
  assign y_rnd = y_sum + (y_sum[AW-1] ? AW'({FRAC_BITS{1'b1}}) : AW'(0));
  assign count_inc = {1'b0, step_count} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (start_acc) begin
      line_active <= steps != '0;
    end else if (adv_acc && line_active && count_inc >= {1'b0, total_steps}) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) begin
      x_accum <= {x_s, {FRAC_BITS{1'b0}}};
      y_accum <= {y_s, {FRAC_BITS{1'b0}}};
      end_x <= x_e;
      end_y <= y_e;
      total_steps <= steps;
      step_count <= '0;
      pattern_pos <= '0;
      x_neg <= dx[C];
      y_neg <= dy[C];
      y_mag <= dy_mag;
      point_x <= x_s;
      point_y <= y_s;
      lit <= 1'b1;
      last <= steps == '0;
    end else if (adv_acc && line_active) begin
      x_accum <= x_sum;
      y_accum <= y_sum;
      step_count <= count_inc[C-1:0];
      pattern_pos <= pos_next;
      lit <= pat_lit;
      if (count_inc >= {1'b0, total_steps}) begin
        point_x <= end_x;
        point_y <= end_y;
        last <= 1'b1;
      end else begin
        point_x <= x_rnd[AW-1:FRAC_BITS];
        point_y <= y_rnd[AW-1:FRAC_BITS];
        last <= 1'b0;
      end
    end
    if (div_stat.done && state == ST_DIV_X) begin
      x_step <= q_signed;
    end
    if (div_stat.done && state == ST_DIV_Y) begin
      y_step <= q_signed;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = OUT_W'({point_y, point_x});
  assign m_tuser = lit;
  assign m_tlast = last;

endmodule

// ----- sim/dda_line_checker.sv -----
// stream checker for the styled dda line rasteriser: predicts every point from the
// accepted words and register writes, then compares the output words in order
// depends on dda_pkg for register indexes, style codes and pattern constants
module dda_line_checker #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dda_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dda_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  s_tvalid,
  input  logic                                  s_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  input  logic                                  s_tuser,
  input  logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  input  logic                                  m_tuser,
  input  logic                                  m_tlast,
  output int                                    fail_count,
  output int                                    pending
);
  import dda_pkg::*;

  localparam int ACC_W = COORD_BITS + FRAC_BITS;
  localparam int INC_W = FRAC_BITS + 2;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  lit;
    logic                  last;
  } point_t;

  point_t                  points_due[$];
  logic [1:0]              style;
  logic [5:0]              dash_len;
  logic signed [ACC_W-1:0] x_acc, y_acc;
  logic signed [INC_W-1:0] x_inc, y_inc;
  logic [COORD_BITS-1:0]   end_x, end_y;
  logic [COORD_BITS-1:0]   total_steps, steps_done;
  logic [6:0]              pat_pos;
  logic                    drawing;

  function automatic int dash_eff();
    return (dash_len < DASH_LENGTH_MIN) ? int'(DASH_LENGTH_MIN) : int'(dash_len);
  endfunction

  function automatic int pattern_period();
    case (style)
      STYLE_DASHED:   return dash_eff();
      STYLE_DASH_DOT: return dash_eff() + int'(DASH_DOT_EXTRA);
      default:        return 1;
    endcase
  endfunction

  function automatic logic pattern_lit(input int p);
    case (style)
      STYLE_DASHED:   return p > 1;
      STYLE_DASH_DOT: return (p >= 1 && p <= dash_eff()) || p == dash_eff() + int'(DOT_OFFSET);
      default:        return 1'b1;
    endcase
  endfunction

  // magnitude shifted up and divided, sign put back afterwards
  function automatic logic signed [INC_W-1:0] increment(input int d, input int n);
    longint q;
    q = (longint'(d < 0 ? -d : d) <<< FRAC_BITS) / longint'(n);
    return (d < 0) ? INC_W'(-q) : INC_W'(q);
  endfunction

  // truncation toward zero, done wide so the most negative position negates safely
  function automatic logic [COORD_BITS-1:0] whole_part(input logic signed [ACC_W-1:0] a);
    longint v;
    v = a;
    v = (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
    return v[COORD_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    point_t got, want;
    int xs, ys, xe, ye, dx, dy, adx, ady, span;
    if (rst) begin
      points_due.delete();
      style = STYLE_SOLID;
      dash_len = DASH_LENGTH_RESET;
      x_acc = '0;
      y_acc = '0;
      x_inc = '0;
      y_inc = '0;
      end_x = '0;
      end_y = '0;
      total_steps = '0;
      steps_done = '0;
      pat_pos = '0;
      drawing = 1'b0;
      fail_count = 0;
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.x = m_tdata[COORD_BITS-1:0];
        got.y = m_tdata[2*COORD_BITS-1:COORD_BITS];
        got.lit = m_tuser;
        got.last = m_tlast;
        if (points_due.size() == 0) begin
          $error("point (%0d,%0d) arrived with none due", $signed(got.x), $signed(got.y));
          fail_count++;
        end else begin
          want = points_due.pop_front();
          if (got.x !== want.x) begin
            $error("point_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
            fail_count++;
          end
          if (got.y !== want.y) begin
            $error("point_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
            fail_count++;
          end
          if (got.lit !== want.lit) begin
            $error("lit: expected %0b, got %0b", want.lit, got.lit);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fail_count++;
          end
        end
      end

      if (cfg_we) begin
        if (cfg_index == CFG_LINE_STYLE) begin
          style = cfg_data[1:0];
        end else if (cfg_index == CFG_DASH_LENGTH) begin
          dash_len = cfg_data[5:0];
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser == ACTION_START) begin
          xs = $signed(s_tdata[COORD_BITS-1:0]);
          ys = $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);
          xe = $signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
          ye = $signed(s_tdata[4*COORD_BITS-1:3*COORD_BITS]);
          dx = xe - xs;
          dy = ye - ys;
          adx = dx < 0 ? -dx : dx;
          ady = dy < 0 ? -dy : dy;
          span = adx > ady ? adx : ady;
          x_acc = ACC_W'(xs * (1 << FRAC_BITS));
          y_acc = ACC_W'(ys * (1 << FRAC_BITS));
          end_x = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
          end_y = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
          total_steps = COORD_BITS'(span);
          steps_done = '0;
          pat_pos = '0;
          if (span == 0) begin
            x_inc = '0;
            y_inc = '0;
            drawing = 1'b0;
          end else begin
            x_inc = increment(dx, span);
            y_inc = increment(dy, span);
            drawing = 1'b1;
          end
          want.x = s_tdata[COORD_BITS-1:0];
          want.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
          want.lit = 1'b1;
          want.last = (span == 0);
          points_due.push_back(want);
        end else if (drawing) begin
          x_acc = x_acc + x_inc;
          y_acc = y_acc + y_inc;
          steps_done = steps_done + 1'b1;
          // wraps early too when the period shrank mid-line
          pat_pos = (int'(pat_pos) + 1 >= pattern_period()) ? '0 : pat_pos + 1'b1;
          want.lit = pattern_lit(int'(pat_pos));
          if (steps_done >= total_steps) begin
            drawing = 1'b0;
            want.x = end_x;
            want.y = end_y;
            want.last = 1'b1;
          end else begin
            want.x = whole_part(x_acc);
            want.y = whole_part(y_acc);
            want.last = 1'b0;
          end
          points_due.push_back(want);
        end
      end
      pending = points_due.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// top of the rasteriser regression: clock, reset, register settings and word stimulus
// instantiates dda_styled_line_rasterizer_core and dda_line_checker; uses dda_pkg
module tb_top;
  import dda_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS = 16;
  localparam int S_W = ((4*COORD_BITS+7)/8)*8;
  localparam int M_W = ((2*COORD_BITS+7)/8)*8;
  localparam int DRAIN_CYCLES = 2*(FRAC_BITS+2) + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 80;
  localparam int HOLD_AT_WORD = 300;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] STYLE_UNKNOWN = 2'd3;
  localparam int C_MIN = -(1 << (COORD_BITS-1));
  localparam int C_MAX = (1 << (COORD_BITS-1)) - 1;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_W-1:0]        s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_W-1:0]        m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;
  int                    items_sent;
  int                    rx_words;
  logic                  tx_steady;
  logic                  rx_steady;

  dda_styled_line_rasterizer_core #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  dda_line_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int rand_coord();
    return int'($urandom_range(0, (1 << COORD_BITS) - 1)) + C_MIN;
  endfunction

  function automatic int clamp_coord(input int v);
    return v < C_MIN ? C_MIN : (v > C_MAX ? C_MAX : v);
  endfunction

  function automatic int line_span(input int xs, ys, xe, ye);
    int adx, ady;
    adx = xe > xs ? xe - xs : xs - xe;
    ady = ye > ys ? ye - ys : ys - ye;
    return adx > ady ? adx : ady;
  endfunction

  // entered and left at a falling edge; tvalid stays high across back-to-back words
  task automatic send_word(input logic action, input int xs, ys, xe, ye);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= action;
    s_tdata <= S_W'({ye[COORD_BITS-1:0], xe[COORD_BITS-1:0],
                     ys[COORD_BITS-1:0], xs[COORD_BITS-1:0]});
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_advance();
    send_word(ACTION_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic draw_line(input int xs, ys, xe, ye, input int advances);
    send_word(ACTION_START, xs, ys, xe, ye);
    repeat (advances) send_advance();
  endtask

  // only once the output side has drained and the divider has had time to finish
  task automatic set_style(input logic [1:0] style, input logic [5:0] len);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LINE_STYLE;
    cfg_data <= {4'($urandom_range(0, 15)), style};
    @(negedge clk);
    cfg_index <= CFG_DASH_LENGTH;
    cfg_data <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_run(input int target);
    int first, r, len, xs, ys, xe, ye, span, adv;
    first = items_sent;
    // a line is usually still open from the last run, so these step it under new values
    repeat ($urandom_range(5, 25)) send_advance();
    while (items_sent - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 160);
        xs = rand_coord();
        ys = rand_coord();
        xe = clamp_coord(xs + int'($urandom_range(0, 2*len)) - len);
        ye = clamp_coord(ys + int'($urandom_range(0, 2*len)) - len);
        span = line_span(xs, ys, xe, ye);
        adv = span;
        r = $urandom_range(0, 9);
        if (r == 0) begin
          adv = span + $urandom_range(1, 3);
        end else if (r == 1) begin
          adv = $urandom_range(0, span);
        end
        draw_line(xs, ys, xe, ye, adv);
      end else if (r < 92) begin
        draw_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  $urandom_range(0, 12));
      end else begin
        send_advance();
      end
    end
    xs = $urandom_range(0, 2000) - 1000;
    ys = $urandom_range(0, 2000) - 1000;
    draw_line(xs, ys, xs + 150, ys - int'($urandom_range(0, 150)), 30);
  endtask

  // sink with random back-pressure and one long hold so the block backs up
  initial begin
    int gap;
    m_tready = 1'b0;
    rx_words = 0;
    rx_steady = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 6);
      if (rx_words == HOLD_AT_WORD) gap = HOLD_CYCLES;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      rx_words++;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACTION_START;
    items_sent = 0;
    tx_steady = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // short line to its endpoint, then an advance with nothing open
    draw_line(0, 0, 3, 1, 3);
    send_advance();
    // zero-length line gives the start point only
    draw_line(5, -7, 5, -7, 0);
    send_advance();
    // full-range diagonals and a vertical at the most negative x
    draw_line(C_MIN, C_MIN, C_MAX, C_MAX, 2);
    draw_line(C_MAX, C_MAX, C_MIN, C_MIN, 2);
    draw_line(C_MIN, C_MAX, C_MIN, C_MIN, 2);
    // negative coordinates truncate toward zero
    draw_line(-1, -1, -4, -9, 8);

    set_style(STYLE_DASHED, 6'd2);
    random_run(PHASE_ITEMS);
    set_style(STYLE_DASH_DOT, 6'd63);
    random_run(PHASE_ITEMS);
    set_style(STYLE_DASHED, 6'd63);
    random_run(PHASE_ITEMS);
    set_style(STYLE_DASH_DOT, 6'd2);
    random_run(PHASE_ITEMS);
    set_style(STYLE_UNKNOWN, 6'd0);
    random_run(PHASE_ITEMS);
    set_style(STYLE_DASHED, 6'd1);
    random_run(PHASE_ITEMS);
    set_style(STYLE_DASH_DOT, 6'd0);
    random_run(PHASE_ITEMS);
    set_style(STYLE_DASH_DOT, 6'($urandom_range(2, 63)));
    random_run(PHASE_ITEMS);
    set_style(STYLE_SOLID, 6'($urandom_range(0, 63)));
    random_run(PHASE_ITEMS);

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
